[rtl/mi3_pkg.sv]
package mi3_pkg;

    // Determinant field width, Q32.32 at the default entry format
    localparam int DET_WIDTH   = 64;
    localparam int NUM_ENTRIES = 9;

    // Queue between the front and back, and the output queue
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    // Cofactor of inverse entry k = a[p]*a[q] - a[r]*a[s], row-major indices
    localparam logic [3:0] COF_IDX [NUM_ENTRIES][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Queue status seen by the stage that feeds or drains it
    typedef struct packed {
        logic full;
        logic empty;
    } mi3_fifo_stat_t;

endpackage

[rtl/mi3_in_if.sv]
interface mi3_in_if #(
    parameter int ENTRY_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [ENTRY_WIDTH-1:0] a_xx;
    logic signed [ENTRY_WIDTH-1:0] a_xy;
    logic signed [ENTRY_WIDTH-1:0] a_xz;
    logic signed [ENTRY_WIDTH-1:0] a_yx;
    logic signed [ENTRY_WIDTH-1:0] a_yy;
    logic signed [ENTRY_WIDTH-1:0] a_yz;
    logic signed [ENTRY_WIDTH-1:0] a_zx;
    logic signed [ENTRY_WIDTH-1:0] a_zy;
    logic signed [ENTRY_WIDTH-1:0] a_zz;

    modport source (
        output valid, a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz,
        input  ready
    );
    modport sink (
        input  valid, a_xx, a_xy, a_xz, a_yx, a_yy, a_yz, a_zx, a_zy, a_zz,
        output ready
    );
endinterface

[rtl/mi3_out_if.sv]
interface mi3_out_if
    import mi3_pkg::*;
#(
    parameter int ENTRY_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [ENTRY_WIDTH-1:0] inv_xx;
    logic signed [ENTRY_WIDTH-1:0] inv_xy;
    logic signed [ENTRY_WIDTH-1:0] inv_xz;
    logic signed [ENTRY_WIDTH-1:0] inv_yx;
    logic signed [ENTRY_WIDTH-1:0] inv_yy;
    logic signed [ENTRY_WIDTH-1:0] inv_yz;
    logic signed [ENTRY_WIDTH-1:0] inv_zx;
    logic signed [ENTRY_WIDTH-1:0] inv_zy;
    logic signed [ENTRY_WIDTH-1:0] inv_zz;
    logic signed [DET_WIDTH-1:0]   determinant;
    logic                          singular;
    logic                          overflow;

    modport source (
        output valid, inv_xx, inv_xy, inv_xz, inv_yx, inv_yy, inv_yz, inv_zx, inv_zy,
               inv_zz, determinant, singular, overflow,
        input  ready
    );
    modport sink (
        input  valid, inv_xx, inv_xy, inv_xz, inv_yx, inv_yy, inv_yz, inv_zx, inv_zy,
               inv_zz, determinant, singular, overflow,
        output ready
    );
endinterface

[rtl/mi3_fifo.sv]
module mi3_fifo
    import mi3_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output mi3_fifo_stat_t   stat
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == NW'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

[rtl/mi3_front.sv]
module mi3_front
    import mi3_pkg::*;
#(
    parameter int ENTRY_WIDTH = 32
)(
    input  logic                clk,
    input  logic                rst_n,
    mi3_in_if.sink              in_ch,
    input  mi3_fifo_stat_t      q_stat,
    output logic                push,
    output logic [9*(2*ENTRY_WIDTH+1)+3*ENTRY_WIDTH:0] push_data
);
    localparam int EW = ENTRY_WIDTH;
    localparam int CW = 2*EW + 1;   // cofactor
    localparam int DW = 3*EW + 1;   // determinant

    logic                 en;
    logic                 v_reg [6];
    logic signed [EW-1:0] a_in  [NUM_ENTRIES];
    logic signed [EW-1:0] a_reg [NUM_ENTRIES];
    logic signed [2*EW-1:0] prod_p_reg [NUM_ENTRIES];
    logic signed [2*EW-1:0] prod_q_reg [NUM_ENTRIES];
    logic signed [EW-1:0] row1_reg [3];
    logic signed [EW-1:0] row2_reg [3];
    logic signed [CW-1:0] cof2_reg [NUM_ENTRIES];
    logic signed [CW-1:0] cof3_reg [NUM_ENTRIES];
    logic signed [CW-1:0] cof4_reg [NUM_ENTRIES];
    logic signed [CW-1:0] cof5_reg [NUM_ENTRIES];
    logic signed [2*EW:0] lo_reg   [3];
    logic signed [2*EW:0] hi_reg   [3];
    logic        [DW-1:0] term_reg [3];
    logic        [DW-1:0] det_reg;

    // Pipeline advances while the queue has room
    assign en          = !q_stat.full;
    assign in_ch.ready = en;

    always_comb
    begin
        a_in[0] = in_ch.a_xx;
        a_in[1] = in_ch.a_xy;
        a_in[2] = in_ch.a_xz;
        a_in[3] = in_ch.a_yx;
        a_in[4] = in_ch.a_yy;
        a_in[5] = in_ch.a_yz;
        a_in[6] = in_ch.a_zx;
        a_in[7] = in_ch.a_zy;
        a_in[8] = in_ch.a_zz;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 6; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_ch.valid;
            for (int s = 1; s < 6; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // Datapath: capture, products, cofactors, split det products, terms, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                a_reg[k]      <= a_in[k];
                prod_p_reg[k] <= a_reg[COF_IDX[k][0]] * a_reg[COF_IDX[k][1]];
                prod_q_reg[k] <= a_reg[COF_IDX[k][2]] * a_reg[COF_IDX[k][3]];
                cof2_reg[k]   <= $signed({prod_p_reg[k][2*EW-1], prod_p_reg[k]})
                               - $signed({prod_q_reg[k][2*EW-1], prod_q_reg[k]});
                cof3_reg[k]   <= cof2_reg[k];
                cof4_reg[k]   <= cof3_reg[k];
                cof5_reg[k]   <= cof4_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                row1_reg[j] <= a_reg[j];
                row2_reg[j] <= row1_reg[j];
                lo_reg[j]   <= row2_reg[j] * $signed({1'b0, cof2_reg[3*j][EW-1:0]});
                hi_reg[j]   <= row2_reg[j] * $signed(cof2_reg[3*j][CW-1:EW]);
                term_reg[j] <= {hi_reg[j], {EW{1'b0}}} + {{EW{lo_reg[j][2*EW]}}, lo_reg[j]};
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    // Beat into the queue
    assign push = en && v_reg[5];

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            push_data[k*CW +: CW] = cof5_reg[k];
        end
        push_data[9*CW +: DW] = det_reg;
    end

endmodule

[rtl/mi3_back.sv]
module mi3_back
    import mi3_pkg::*;
#(
    parameter int ENTRY_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [9*(2*ENTRY_WIDTH+1)+3*ENTRY_WIDTH:0] pop_data,
    input  mi3_fifo_stat_t      q_stat,
    output logic                pop,
    input  mi3_fifo_stat_t      o_stat,
    output logic                push,
    output logic [9*ENTRY_WIDTH+DET_WIDTH+1:0] push_data
);
    localparam int EW  = ENTRY_WIDTH;
    localparam int FW  = FRAC_BITS;
    localparam int CW  = 2*EW + 1;
    localparam int DW  = 3*EW + 1;
    localparam int MW  = 3*EW;                      // determinant magnitude
    localparam int NUMW = 2*EW + 2*FW;              // shifted cofactor magnitude
    localparam int W   = (4*EW + 1 > NUMW) ? 4*EW + 1 : NUMW;
    localparam int QW  = EW + 1;                    // truncated quotient bits
    localparam int NS  = EW + 2;                    // divider stages incl. setup
    localparam int DMW = (MW + 1 - FW > DET_WIDTH + 1) ? MW + 1 - FW : DET_WIDTH + 1;
    localparam logic [EW+1:0]  QLIM = (EW+2)'(1) << (EW - 1);
    localparam logic [DMW-1:0] DLIM = DMW'(1) << (DET_WIDTH - 1);
    localparam logic [DMW-1:0] HALF = DMW'(1) << (FW - 1);

    logic en;

    // Unpack / sign stages
    logic                 v_b0_reg, v_b1_reg;
    logic signed [CW-1:0] cof_b0_reg [NUM_ENTRIES];
    logic        [DW-1:0] det_b0_reg;
    logic [2*EW-1:0]      cmag_b1_reg [NUM_ENTRIES];
    logic                 neg_b1_reg  [NUM_ENTRIES];
    logic [MW-1:0]        dmag_b1_reg;
    logic                 dneg_b1_reg, sing_b1_reg;

    // Divider stages
    logic                 vd_reg   [NS];
    logic [W-1:0]         rem_reg  [NS][NUM_ENTRIES];
    logic [QW-1:0]        quo_reg  [NS][NUM_ENTRIES];
    logic                 big_reg  [NS][NUM_ENTRIES];
    logic                 neg_reg  [NS][NUM_ENTRIES];
    logic [MW-1:0]        dmag_reg [NS];
    logic                 sing_reg [NS];
    logic [DET_WIDTH-1:0] dcode_reg[NS];
    logic                 dovf_reg [NS];

    // Setup stage next values
    logic [W-1:0]         rem_next [NUM_ENTRIES];
    logic                 big_next [NUM_ENTRIES];
    logic [DET_WIDTH-1:0] dcode_next;
    logic                 dovf_next;
    logic [DMW-1:0]       dm;
    logic [DET_WIDTH-1:0] dlow;

    // Rounding and packing stages
    logic                 vr_reg, vp_reg;
    logic [EW+1:0]        qr_reg  [NUM_ENTRIES];
    logic                 bigr_reg[NUM_ENTRIES];
    logic                 negr_reg[NUM_ENTRIES];
    logic                 singr_reg, dovfr_reg;
    logic [DET_WIDTH-1:0] dcoder_reg;
    logic [EW-1:0]        inv_next [NUM_ENTRIES];
    logic [EW-1:0]        inv_reg  [NUM_ENTRIES];
    logic [DET_WIDTH-1:0] det_next, det_reg;
    logic                 sing_next, sing_out_reg, ovf_next, ovf_reg;

    // Back pipeline advances while the output queue has room
    assign en  = !o_stat.full;
    assign pop = en && !q_stat.empty;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b0_reg <= 1'b0;
            v_b1_reg <= 1'b0;
            for (int s = 0; s < NS; s++)
            begin
                vd_reg[s] <= 1'b0;
            end
            vr_reg <= 1'b0;
            vp_reg <= 1'b0;
        end
        else if (en)
        begin
            v_b0_reg  <= pop;
            v_b1_reg  <= v_b0_reg;
            vd_reg[0] <= v_b1_reg;
            for (int s = 1; s < NS; s++)
            begin
                vd_reg[s] <= vd_reg[s-1];
            end
            vr_reg <= vd_reg[NS-1];
            vp_reg <= vr_reg;
        end
    end

    // Unpack and magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                cof_b0_reg[k]  <= pop_data[k*CW +: CW];
                neg_b1_reg[k]  <= cof_b0_reg[k][CW-1] ^ det_b0_reg[DW-1];
                cmag_b1_reg[k] <= cof_b0_reg[k][CW-1] ? (2*EW)'(-cof_b0_reg[k])
                                                      : (2*EW)'(cof_b0_reg[k]);
            end
            det_b0_reg  <= pop_data[9*CW +: DW];
            dneg_b1_reg <= det_b0_reg[DW-1];
            dmag_b1_reg <= det_b0_reg[DW-1] ? MW'(-det_b0_reg) : MW'(det_b0_reg);
            sing_b1_reg <= (det_b0_reg == '0);
        end
    end

    // Divider setup and determinant field
    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            rem_next[k] = W'(cmag_b1_reg[k]) << (2*FW);
            big_next[k] = rem_next[k] >= (W'(dmag_b1_reg) << (EW + 1));
        end
        // round at full magnitude width, then drop the extra fraction bits
        dm   = DMW'(((MW+1)'(dmag_b1_reg) + (MW+1)'(HALF)) >> FW);
        dlow = dm[DET_WIDTH-1:0];
        if (!dneg_b1_reg && dm >= DLIM)
        begin
            dovf_next  = 1'b1;
            dcode_next = {1'b0, {(DET_WIDTH-1){1'b1}}};
        end
        else if (dneg_b1_reg && dm > DLIM)
        begin
            dovf_next  = 1'b1;
            dcode_next = {1'b1, {(DET_WIDTH-1){1'b0}}};
        end
        else
        begin
            dovf_next  = 1'b0;
            dcode_next = dneg_b1_reg ? ~dlow + 1'b1 : dlow;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                rem_reg[0][k] <= rem_next[k];
                quo_reg[0][k] <= '0;
                big_reg[0][k] <= big_next[k];
                neg_reg[0][k] <= neg_b1_reg[k];
            end
            dmag_reg[0]  <= dmag_b1_reg;
            sing_reg[0]  <= sing_b1_reg;
            dcode_reg[0] <= dcode_next;
            dovf_reg[0]  <= dovf_next;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 1; s < NS; s++)
    begin : g_div
        localparam int BIT = NS - 1 - s;
        logic [W-1:0] shd;

        assign shd = W'(dmag_reg[s-1]) << BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < NUM_ENTRIES; k++)
                begin
                    if (rem_reg[s-1][k] >= shd)
                    begin
                        rem_reg[s][k] <= rem_reg[s-1][k] - shd;
                        quo_reg[s][k] <= quo_reg[s-1][k] | (QW'(1) << BIT);
                    end
                    else
                    begin
                        rem_reg[s][k] <= rem_reg[s-1][k];
                        quo_reg[s][k] <= quo_reg[s-1][k];
                    end
                    big_reg[s][k] <= big_reg[s-1][k];
                    neg_reg[s][k] <= neg_reg[s-1][k];
                end
                dmag_reg[s]  <= dmag_reg[s-1];
                sing_reg[s]  <= sing_reg[s-1];
                dcode_reg[s] <= dcode_reg[s-1];
                dovf_reg[s]  <= dovf_reg[s-1];
            end
        end
    end

    // Round to nearest, ties away from zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                qr_reg[k] <= (EW+2)'(quo_reg[NS-1][k])
                           + (EW+2)'({rem_reg[NS-1][k], 1'b0} >= (W+1)'(dmag_reg[NS-1]));
                bigr_reg[k] <= big_reg[NS-1][k];
                negr_reg[k] <= neg_reg[NS-1][k];
            end
            singr_reg  <= sing_reg[NS-1];
            dovfr_reg  <= dovf_reg[NS-1];
            dcoder_reg <= dcode_reg[NS-1];
        end
    end

    // Saturate, sign and handle a zero determinant
    always_comb
    begin
        logic          any_sat;
        logic          negq;
        logic [EW-1:0] qlow;
        any_sat = 1'b0;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            negq = negr_reg[k] && (bigr_reg[k] || qr_reg[k] != '0);
            qlow = qr_reg[k][EW-1:0];
            if (!negq && (bigr_reg[k] || qr_reg[k] >= QLIM))
            begin
                inv_next[k] = {1'b0, {(EW-1){1'b1}}};
                any_sat     = 1'b1;
            end
            else if (negq && (bigr_reg[k] || qr_reg[k] > QLIM))
            begin
                inv_next[k] = {1'b1, {(EW-1){1'b0}}};
                any_sat     = 1'b1;
            end
            else
            begin
                inv_next[k] = negq ? ~qlow + 1'b1 : qlow;
            end
        end
        if (singr_reg)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                inv_next[k] = '0;
            end
            det_next  = '0;
            sing_next = 1'b1;
            ovf_next  = 1'b0;
        end
        else
        begin
            det_next  = dcoder_reg;
            sing_next = 1'b0;
            ovf_next  = dovfr_reg || any_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
            begin
                inv_reg[k] <= inv_next[k];
            end
            det_reg      <= det_next;
            sing_out_reg <= sing_next;
            ovf_reg      <= ovf_next;
        end
    end

    // Beat into the output queue
    assign push = en && vp_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            push_data[k*EW +: EW] = inv_reg[k];
        end
        push_data[9*EW +: DET_WIDTH] = det_reg;
        push_data[9*EW + DET_WIDTH]     = sing_out_reg;
        push_data[9*EW + DET_WIDTH + 1] = ovf_reg;
    end

endmodule

[rtl/matrix3x3_inverse_unit.sv]
// 3x3 matrix inverse by adjugate, fixed point.
// Throughput: one matrix per cycle while the front-to-back queue has room; each of the nine pipelined dividers
// resolves one quotient bit per stage, ENTRY_WIDTH + 1 stages deep.
// Reset clears valid bits and queue pointers only; no clearing pass.
module matrix3x3_inverse_unit
    import mi3_pkg::*;
#(
    parameter int ENTRY_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)(
    input  logic       clk,
    input  logic       rst_n,
    mi3_in_if.sink     in_ch,
    mi3_out_if.source  out_ch
);
    localparam int EW  = ENTRY_WIDTH;
    localparam int QDW = 9*(2*EW + 1) + 3*EW + 1;
    localparam int ODW = 9*EW + DET_WIDTH + 2;

    logic           q_push, q_pop, o_push, o_pop;
    logic [QDW-1:0] q_push_data, q_pop_data;
    logic [ODW-1:0] o_push_data, o_pop_data;
    mi3_fifo_stat_t q_stat, o_stat;

    // Front: products, cofactors and determinant
    mi3_front #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    mi3_fifo #(
        .WIDTH (QDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    // Back: division, rounding and saturation
    mi3_back #(
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (q_pop_data),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .o_stat    (o_stat),
        .push      (o_push),
        .push_data (o_push_data)
    );

    mi3_fifo #(
        .WIDTH (ODW),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (o_push),
        .push_data (o_push_data),
        .pop       (o_pop),
        .pop_data  (o_pop_data),
        .stat      (o_stat)
    );

    // Result port
    assign out_ch.valid       = !o_stat.empty;
    assign o_pop              = out_ch.valid && out_ch.ready;
    assign out_ch.inv_xx      = o_pop_data[0*EW +: EW];
    assign out_ch.inv_xy      = o_pop_data[1*EW +: EW];
    assign out_ch.inv_xz      = o_pop_data[2*EW +: EW];
    assign out_ch.inv_yx      = o_pop_data[3*EW +: EW];
    assign out_ch.inv_yy      = o_pop_data[4*EW +: EW];
    assign out_ch.inv_yz      = o_pop_data[5*EW +: EW];
    assign out_ch.inv_zx      = o_pop_data[6*EW +: EW];
    assign out_ch.inv_zy      = o_pop_data[7*EW +: EW];
    assign out_ch.inv_zz      = o_pop_data[8*EW +: EW];
    assign out_ch.determinant = o_pop_data[9*EW +: DET_WIDTH];
    assign out_ch.singular    = o_pop_data[9*EW + DET_WIDTH];
    assign out_ch.overflow    = o_pop_data[9*EW + DET_WIDTH + 1];

    // Queues are never written while full
    a_queue_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |-> !o_stat.full)
        else $error("output queue written while full");

    // A singular result carries zeros and no overflow
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.singular) |->
            (!out_ch.overflow && out_ch.determinant == '0 && out_ch.inv_xx == '0
             && out_ch.inv_zz == '0))
        else $error("singular result not cleared");

endmodule

[verif/mi3_inverse_checker.sv]
`timescale 1ns / 100ps

module mi3_inverse_checker
    import mi3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mi3_in_if    in_ch,
    mi3_out_if   out_ch,
    output int   errors,
    output int   pending
);

    typedef logic signed [31:0] entry_t;

    typedef struct {
        logic [31:0] inv [NUM_ENTRIES];
        logic [63:0] det;
        logic        singular;
        logic        overflow;
    } inverse_result_t;

    inverse_result_t expected_results [$];

    string inv_names [NUM_ENTRIES] = '{"inv_xx", "inv_xy", "inv_xz", "inv_yx", "inv_yy",
                                       "inv_yz", "inv_zx", "inv_zy", "inv_zz"};

    // Sign and magnitude to a saturated two's complement code
    function automatic logic [63:0] pack_code(input logic neg, input logic [255:0] mag,
                                              input int width, inout logic ovf);
        logic [255:0] lim;
        logic [63:0]  low;
        logic [63:0]  wmask;
        lim = 256'(1) << (width - 1);
        if (!neg && mag >= lim)
        begin
            mag = lim - 1;
            ovf = 1'b1;
        end
        else if (neg && mag > lim)
        begin
            mag = lim;
            ovf = 1'b1;
        end
        low = mag[63:0];
        if (neg)
            low = -low;
        wmask = (width == 64) ? {64{1'b1}} : ((64'd1 << width) - 1);
        return low & wmask;
    endfunction

    // Exact cofactors and determinant, then rounded quotients
    function automatic inverse_result_t compute_inverse(input entry_t m [NUM_ENTRIES]);
        inverse_result_t r;
        logic signed [127:0] a [NUM_ENTRIES];
        logic signed [127:0] cof [NUM_ENTRIES];
        logic signed [127:0] det;
        logic [255:0] dmag, num, q, rem, dm, cmag;
        logic dneg, neg, ovf;
        for (int k = 0; k < NUM_ENTRIES; k++)
            a[k] = m[k];
        for (int k = 0; k < NUM_ENTRIES; k++)
            cof[k] = a[COF_IDX[k][0]] * a[COF_IDX[k][1]]
                   - a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
        det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
        ovf = 1'b0;
        if (det == 0)
        begin
            for (int k = 0; k < NUM_ENTRIES; k++)
                r.inv[k] = '0;
            r.det = '0;
            r.singular = 1'b1;
            r.overflow = 1'b0;
            return r;
        end
        dneg = det < 0;
        dmag = dneg ? 256'(-det) : 256'(det);
        dm = (dmag + (256'(1) << 15)) >> 16;
        r.det = pack_code(dneg, dm, DET_WIDTH, ovf);
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            neg = (cof[k] < 0) != dneg;
            cmag = (cof[k] < 0) ? 256'(-cof[k]) : 256'(cof[k]);
            num = cmag << 32;
            q = num / dmag;
            rem = num % dmag;
            if ((rem << 1) >= dmag)
                q = q + 1;
            if (q == 0)
                neg = 1'b0;
            r.inv[k] = 32'(pack_code(neg, q, 32, ovf));
        end
        r.singular = 1'b0;
        r.overflow = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors = 0;
    end

    assign pending = expected_results.size();

    always @(posedge clk)
    begin
        entry_t m [NUM_ENTRIES];
        logic [31:0] got_inv [NUM_ENTRIES];
        inverse_result_t want;
        if (rst_n)
        begin
            // Input beat: predict
            if (in_ch.valid && in_ch.ready)
            begin
                m = '{in_ch.a_xx, in_ch.a_xy, in_ch.a_xz, in_ch.a_yx, in_ch.a_yy,
                      in_ch.a_yz, in_ch.a_zx, in_ch.a_zy, in_ch.a_zz};
                expected_results.push_back(compute_inverse(m));
            end
            // Result beat: compare with oldest
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("result beat with nothing expected at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    got_inv = '{out_ch.inv_xx, out_ch.inv_xy, out_ch.inv_xz, out_ch.inv_yx,
                                out_ch.inv_yy, out_ch.inv_yz, out_ch.inv_zx, out_ch.inv_zy,
                                out_ch.inv_zz};
                    for (int k = 0; k < NUM_ENTRIES; k++)
                        if (got_inv[k] !== want.inv[k])
                            report_mismatch(inv_names[k], 64'(got_inv[k]), 64'(want.inv[k]));
                    if (out_ch.determinant !== want.det)
                        report_mismatch("determinant", out_ch.determinant, want.det);
                    if (out_ch.singular !== want.singular)
                        report_mismatch("singular", 64'(out_ch.singular), 64'(want.singular));
                    if (out_ch.overflow !== want.overflow)
                        report_mismatch("overflow", 64'(out_ch.overflow), 64'(want.overflow));
                end
            end
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import mi3_pkg::*;

    typedef logic signed [31:0] entry_t;
    typedef entry_t matrix_t [NUM_ENTRIES];

    localparam int RANDOM_ITEMS  = 1830;
    localparam int LATENCY_WAIT  = 80;
    localparam int IDLE_LIMIT    = 20000;
    localparam entry_t ONE       = 32'sh0001_0000;
    localparam entry_t MAX_ENTRY = 32'sh7fff_ffff;
    localparam entry_t MIN_ENTRY = 32'sh8000_0000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   burst_left;

    mi3_in_if  #(.ENTRY_WIDTH(32)) in_ch ();
    mi3_out_if #(.ENTRY_WIDTH(32)) out_ch ();

    matrix3x3_inverse_unit #(.ENTRY_WIDTH(32), .FRAC_BITS(16)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mi3_inverse_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one matrix; returns after its beat, right after the edge
    task automatic send_matrix(input matrix_t m);
        in_ch.valid <= 1'b1;
        in_ch.a_xx <= m[0]; in_ch.a_xy <= m[1]; in_ch.a_xz <= m[2];
        in_ch.a_yx <= m[3]; in_ch.a_yy <= m[4]; in_ch.a_yz <= m[5];
        in_ch.a_zx <= m[6]; in_ch.a_zy <= m[7]; in_ch.a_zz <= m[8];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // burst pacing
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 15);
        end
    endtask

    function automatic entry_t rand_small(input int unsigned span);
        return entry_t'($urandom_range(0, 2 * span)) - entry_t'(span);
    endfunction

    function automatic entry_t pick_extreme();
        case ($urandom_range(0, 6))
            0: return MAX_ENTRY;
            1: return MIN_ENTRY;
            2: return '0;
            3: return 32'sd1;
            4: return -32'sd1;
            5: return ONE;
            default: return -ONE;
        endcase
    endfunction

    function automatic matrix_t diag(input entry_t d0, input entry_t d1, input entry_t d2);
        matrix_t m;
        m = '{default: '0};
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        return m;
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int unsigned kind;
        int unsigned k;
        entry_t s;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < NUM_ENTRIES; i++)
            m[i] = rand_small(32'h4_0000);
        case (kind)
            4: for (int i = 0; i < NUM_ENTRIES; i++) m[i] = $urandom;
            5:
            begin
                // rank deficient: a row is a small multiple of another
                k = $urandom_range(0, 2);
                s = rand_small(3);
                for (int c = 0; c < 3; c++)
                    m[3 * ((k + 1) % 3) + c] = m[3 * k + c] * s;
            end
            6: for (int i = 0; i < NUM_ENTRIES; i++) m[i] = pick_extreme();
            7: for (int i = 0; i < NUM_ENTRIES; i++) m[i] = rand_small(8);
            8: for (int i = 0; i < NUM_ENTRIES; i++)
                   m[i] = rand_small(32'h4000_0000);
            9:
            begin
                s = $urandom;
                m = diag(s, s, s);
                if ($urandom_range(0, 1))
                    m[$urandom_range(0, 8)] = $urandom;
            end
            default: ;
        endcase
        return m;
    endfunction

    // Result side: random ready, a long hold-off, then a ready style drawn at random for each run
    initial
    begin
        int unsigned style;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        repeat (600)
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        // long hold-off so the pipeline backs up into the input
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        forever
        begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(16, 64))
            begin
                @(posedge clk);
                case (style)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ~out_ch.ready;
                endcase
            end
        end
    end

    // Watchdog on cycles without any beat
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        matrix_t m;
        burst_left = 0;
        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.a_xx <= '0; in_ch.a_xy <= '0; in_ch.a_xz <= '0;
        in_ch.a_yx <= '0; in_ch.a_yy <= '0; in_ch.a_yz <= '0;
        in_ch.a_zx <= '0; in_ch.a_zy <= '0; in_ch.a_zz <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, scaled, zero, extremes, singular, tiny determinant
        send_matrix(diag(ONE, ONE, ONE));
        send_matrix(diag(-ONE, -ONE, -ONE));
        send_matrix(diag(ONE * 2, ONE / 2, -ONE * 4));
        send_matrix('{default: '0});
        send_matrix('{default: MAX_ENTRY});
        send_matrix('{default: MIN_ENTRY});
        send_matrix(diag(MAX_ENTRY, MAX_ENTRY, MAX_ENTRY));
        send_matrix(diag(MIN_ENTRY, MIN_ENTRY, MIN_ENTRY));
        send_matrix(diag(MIN_ENTRY, MAX_ENTRY, MIN_ENTRY));
        send_matrix(diag(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag(-32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag(32'sd1, 32'sd2, 32'sd3));
        send_matrix('{ONE, ONE * 2, ONE * 3, ONE * 2, ONE * 4, ONE * 6, ONE, 0, -ONE});
        send_matrix('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
        send_matrix('{MAX_ENTRY, MIN_ENTRY, MAX_ENTRY, MIN_ENTRY, MAX_ENTRY, MIN_ENTRY,
                      32'sd1, -32'sd1, 32'sd0});
        send_matrix('{ONE, 32'sd1, 0, 32'sd1, ONE, 0, 0, 0, MAX_ENTRY});
        send_matrix('{32'sh0000_8000, 0, 0, 0, 32'sh0000_8000, 0, 0, 0, 32'sh0000_8000});
        send_matrix('{ONE * 3, ONE, 0, ONE, ONE * 3, ONE, 0, ONE, ONE * 3});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // drain once completely mid-run
            if (n == RANDOM_ITEMS / 2)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
                repeat (LATENCY_WAIT) @(posedge clk);
            end
            m = random_matrix();
            send_matrix(m);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/mi3_pkg.sv
rtl/mi3_in_if.sv
rtl/mi3_out_if.sv
rtl/mi3_fifo.sv
rtl/mi3_front.sv
rtl/mi3_back.sv
rtl/matrix3x3_inverse_unit.sv
verif/mi3_inverse_checker.sv
verif/testbench.sv
